[rtl/core/chwr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chwr_pkg
// Shared constants, codes and types of the calculator with history ring.
// ----------------------------------------------------------------------------
package chwr_pkg;

   localparam int HIST_DEPTH = 12;
   localparam int SLOT_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int COUNT_W    = $clog2(HIST_DEPTH + 1);
   localparam int DATA_W     = 32;
   localparam int ITER_COUNT = DATA_W;
   localparam int ITER_W     = $clog2(ITER_COUNT);

   localparam logic [2:0] ACT_ADD  = 3'd0;
   localparam logic [2:0] ACT_SUB  = 3'd1;
   localparam logic [2:0] ACT_MUL  = 3'd2;
   localparam logic [2:0] ACT_DIV  = 3'd3;
   localparam logic [2:0] ACT_LAST = 3'd4;
   localparam logic [2:0] ACT_META = 3'd5;
   localparam logic [2:0] ACT_SLOT = 3'd6;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] KIND_LAST = 2'd0;
   localparam logic [1:0] KIND_META = 2'd1;
   localparam logic [1:0] KIND_SLOT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_LOG,
      ST_READ,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_step;
      logic div_step;
      logic log;
      logic read;
      logic reply;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage
`default_nettype wire

[rtl/core/chwr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chwr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chwr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/chwr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chwr_ctrl
// Command sequencer: decodes the accepted word, runs the iteration count
// for multiply and divide, and drives the datapath commands.
// ----------------------------------------------------------------------------
module chwr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [2:0]            req_action,
   output logic                       busy,
   output logic                       rsp_valid,
   output chwr_pkg::dp_cmd_type       dp_cmd
);
   import chwr_pkg::*;

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              iter_last;

   assign iter_last = (iter_ff == ITER_W'(ITER_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_action)
                  ACT_ADD, ACT_SUB:   state_in = ST_LOG;
                  ACT_MUL:            state_in = ST_MUL;
                  ACT_DIV:            state_in = ST_DIV;
                  ACT_LAST, ACT_META: state_in = ST_REPLY;
                  ACT_SLOT:           state_in = ST_READ;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL, ST_DIV: begin
            if (iter_last) begin
               state_in = ST_LOG;
            end
         end
         ST_LOG:   state_in = ST_IDLE;
         ST_READ:  state_in = ST_REPLY;
         ST_REPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd          = '0;
      dp_cmd.load     = (state_ff == ST_IDLE) && start;
      dp_cmd.mul_step = (state_ff == ST_MUL);
      dp_cmd.div_step = (state_ff == ST_DIV);
      dp_cmd.log      = (state_ff == ST_LOG);
      dp_cmd.read     = (state_ff == ST_READ);
      dp_cmd.reply    = (state_ff == ST_REPLY);
      busy            = (state_ff != ST_IDLE);
      rsp_valid_in    = (state_ff == ST_REPLY);
      iter_in         = ((state_ff == ST_MUL) || (state_ff == ST_DIV)) ?
                        iter_ff + ITER_W'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("reply strobe held longer than one cycle");

   a_iter_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_MUL && state_ff != ST_DIV) |-> iter_ff == '0)
      else $error("iteration count not cleared outside multiply/divide");

   a_strobe_after_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == ST_REPLY)
      else $error("reply strobe without reply state");

endmodule
`default_nettype wire

[rtl/core/chwr_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chwr_dp
// Datapath: operand capture, radix-2 shift-add multiplier and restoring
// divider sharing one set of work registers, history ring and reply words.
// ----------------------------------------------------------------------------
module chwr_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  chwr_pkg::dp_cmd_type       dp_cmd,
   input  wire logic [2:0]            req_action,
   input  wire logic [31:0]           req_operand_a,
   input  wire logic [31:0]           req_operand_b,
   input  wire logic [3:0]            req_hist_index,
   output logic      [1:0]            rsp_reply_kind,
   output logic      [31:0]           rsp_last_value,
   output logic      [3:0]            rsp_entry_count,
   output logic      [3:0]            rsp_next_slot,
   output logic                       rsp_entry_present,
   output logic      [1:0]            rsp_entry_op,
   output logic      [31:0]           rsp_entry_a,
   output logic      [31:0]           rsp_entry_b,
   output logic      [31:0]           rsp_entry_value
);
   import chwr_pkg::*;

   logic [2:0]         action_ff;
   logic [DATA_W-1:0]  opnd_a_ff, opnd_b_ff;
   logic [3:0]         index_ff;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0]  sha_ff, sha_in;
   logic [DATA_W-1:0]  shb_ff, shb_in;
   logic [DATA_W-1:0]  last_ff;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [DATA_W:0]    div_sh;
   logic [DATA_W+1:0]  div_diff;
   logic [DATA_W-1:0]  result;
   entry_type          wr_entry, rd_entry;
   logic               present;

   logic [1:0]         kind_ff, kind_in;
   logic [DATA_W-1:0]  out_last_ff, out_last_in;
   logic [3:0]         out_count_ff, out_count_in;
   logic [3:0]         out_slot_ff, out_slot_in;
   logic               out_present_ff, out_present_in;
   entry_type          out_entry_ff, out_entry_in;

   assign div_sh   = {acc_ff, sha_ff[DATA_W-1]};
   assign div_diff = {1'b0, div_sh} - {2'b00, opnd_b_ff};

   always_comb begin
      acc_in = acc_ff;
      sha_in = sha_ff;
      shb_in = shb_ff;
      if (dp_cmd.load) begin
         acc_in = '0;
         sha_in = req_operand_a;
         shb_in = req_operand_b;
      end else if (dp_cmd.mul_step) begin
         if (shb_ff[0]) begin
            acc_in = acc_ff + sha_ff;
         end
         sha_in = {sha_ff[DATA_W-2:0], 1'b0};
         shb_in = {1'b0, shb_ff[DATA_W-1:1]};
      end else if (dp_cmd.div_step) begin
         if (!div_diff[DATA_W+1]) begin
            acc_in = div_diff[DATA_W-1:0];
            sha_in = {sha_ff[DATA_W-2:0], 1'b1};
         end else begin
            acc_in = div_sh[DATA_W-1:0];
            sha_in = {sha_ff[DATA_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      unique case (action_ff[1:0])
         OP_ADD: result = opnd_a_ff + opnd_b_ff;
         OP_SUB: result = opnd_a_ff - opnd_b_ff;
         OP_MUL: result = acc_ff;
         OP_DIV: result = sha_ff;
         default: result = '0;
      endcase
   end

   always_comb begin
      wr_entry.op    = action_ff[1:0];
      wr_entry.a     = opnd_a_ff;
      wr_entry.b     = opnd_b_ff;
      wr_entry.value = result;
      slot_in        = slot_ff;
      count_in       = count_ff;
      if (dp_cmd.log) begin
         slot_in = (slot_ff == SLOT_W'(HIST_DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
         if (count_ff != COUNT_W'(HIST_DEPTH)) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   chwr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HIST_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (dp_cmd.log),
      .wr_addr (slot_ff),
      .wr_data (wr_entry),
      .rd_en   (dp_cmd.read),
      .rd_addr (SLOT_W'(index_ff)),
      .rd_data (rd_entry)
   );

   assign present = (32'(index_ff) < 32'(count_ff));

   always_comb begin
      kind_in        = kind_ff;
      out_last_in    = out_last_ff;
      out_count_in   = out_count_ff;
      out_slot_in    = out_slot_ff;
      out_present_in = out_present_ff;
      out_entry_in   = out_entry_ff;
      if (dp_cmd.reply) begin
         kind_in        = KIND_LAST;
         out_last_in    = '0;
         out_count_in   = '0;
         out_slot_in    = '0;
         out_present_in = 1'b0;
         out_entry_in   = '0;
         unique case (action_ff)
            ACT_LAST: begin
               out_last_in = last_ff;
            end
            ACT_META: begin
               kind_in      = KIND_META;
               out_count_in = 4'(count_ff);
               out_slot_in  = 4'(slot_ff);
            end
            ACT_SLOT: begin
               kind_in        = KIND_SLOT;
               out_present_in = present;
               if (present) begin
                  out_entry_in = rd_entry;
               end
            end
            default: begin
               kind_in = KIND_LAST;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         action_ff <= req_action;
         opnd_a_ff <= req_operand_a;
         opnd_b_ff <= req_operand_b;
         index_ff  <= req_hist_index;
      end
      acc_ff         <= acc_in;
      sha_ff         <= sha_in;
      shb_ff         <= shb_in;
      kind_ff        <= kind_in;
      out_last_ff    <= out_last_in;
      out_count_ff   <= out_count_in;
      out_slot_ff    <= out_slot_in;
      out_present_ff <= out_present_in;
      out_entry_ff   <= out_entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         slot_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (dp_cmd.log) begin
            last_ff <= result;
         end
         slot_ff  <= slot_in;
         count_ff <= count_in;
      end
   end

   assign rsp_reply_kind    = kind_ff;
   assign rsp_last_value    = out_last_ff;
   assign rsp_entry_count   = out_count_ff;
   assign rsp_next_slot     = out_slot_ff;
   assign rsp_entry_present = out_present_ff;
   assign rsp_entry_op      = out_entry_ff.op;
   assign rsp_entry_a       = out_entry_ff.a;
   assign rsp_entry_b       = out_entry_ff.b;
   assign rsp_entry_value   = out_entry_ff.value;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= HIST_DEPTH && 32'(slot_ff) < HIST_DEPTH)
      else $error("history pointer out of range");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.log && (count_ff != COUNT_W'(HIST_DEPTH)) |=>
         count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("history count did not advance on log");

   a_ring_stable: assert property (@(posedge clock) disable iff (reset)
      !$past(dp_cmd.log) && !$past(reset) |-> $stable(slot_ff) && $stable(count_ff))
      else $error("history pointers moved without a log");

endmodule
`default_nettype wire

[rtl/core/calculator_with_history_ring.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// calculator_with_history_ring
// Four-function 32-bit calculator that logs each command into a circular
// history and answers last-result, history-meta and history-slot queries.
// ----------------------------------------------------------------------------
// Add/sub: busy rises in the cycle after accept (log state), then idle again.
// Mul/div: 32 radix-2 iterations, then the log state. A new word is accepted
// only in idle. Last/meta query: rsp_valid is registered from the reply state.
// A slot query passes the read state first (registered history RAM read).
// rsp_valid lasts one cycle. Reset clears the sequencer, last result, count
// and write slot; the history RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module calculator_with_history_ring (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [31:0] req_operand_a,
   input  wire logic [31:0] req_operand_b,
   input  wire logic [3:0]  req_hist_index,
   output logic             rsp_valid,
   output logic [1:0]       rsp_reply_kind,
   output logic [31:0]      rsp_last_value,
   output logic [3:0]       rsp_entry_count,
   output logic [3:0]       rsp_next_slot,
   output logic             rsp_entry_present,
   output logic [1:0]       rsp_entry_op,
   output logic [31:0]      rsp_entry_a,
   output logic [31:0]      rsp_entry_b,
   output logic [31:0]      rsp_entry_value
);
   import chwr_pkg::*;

   dp_cmd_type dp_cmd;

   chwr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .dp_cmd     (dp_cmd)
   );

   chwr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .req_action        (req_action),
      .req_operand_a     (req_operand_a),
      .req_operand_b     (req_operand_b),
      .req_hist_index    (req_hist_index),
      .rsp_reply_kind    (rsp_reply_kind),
      .rsp_last_value    (rsp_last_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_next_slot     (rsp_next_slot),
      .rsp_entry_present (rsp_entry_present),
      .rsp_entry_op      (rsp_entry_op),
      .rsp_entry_a       (rsp_entry_a),
      .rsp_entry_b       (rsp_entry_b),
      .rsp_entry_value   (rsp_entry_value)
   );

endmodule
`default_nettype wire
